// File: hdl/assert_macros.svh
// assertion macros shared by the decoder modules
// clocked on clk, disabled while rst is high; ASSERT_OFF removes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_NOW(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/utd_pkg.sv
// types shared by the utf-8 decoder core and its top level
// no dependencies
`timescale 1ns / 1ps

package utd_pkg;

  // output queue entries, a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [20:0] unit;
    logic        last_of_run;
    logic        end_of_text;
  } out_word_t;

  // up to two output words caused by one input word
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } step_t;

endpackage

// File: hdl/utd_core.sv
// decoder state and per-byte decode: pending count, accumulator, surrogate split
// depends on utd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utd_core import utd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     utf16_mode,
  input  logic     accept,
  input  in_word_t word,
  output step_t    step
);

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] PLANE_BASE  = 21'h010000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [5:0]  LO_SURR_TOP = 6'b110111;

  typedef struct packed {
    logic        two;
    logic [20:0] hi;
    logic [20:0] lo;
  } split_t;

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic [20:0] accumulator;
  logic [20:0] accumulator_next;

  logic        cont;
  logic        lead_emit;
  logic [20:0] lead_val;
  logic [1:0]  lead_pend;
  logic [20:0] lead_acc;
  logic        v1_ok;
  logic [20:0] v1;
  logic        v2_ok;
  logic [20:0] v2;
  split_t      s1;
  split_t      s2;

  function automatic split_t split_value(input logic [20:0] cp, input logic mode);
    split_t     r;
    logic [20:0] v;
    v = cp - PLANE_BASE;
    r.two = mode && (cp > BMP_MAX);
    if (r.two) begin
      r.hi = {5'b0, HI_SURR + {5'b0, v[20:10]}};
      r.lo = {5'b0, LO_SURR_TOP, v[9:0]};
    end else begin
      r.hi = cp;
      r.lo = '0;
    end
    return r;
  endfunction

  assign cont = (word.byte_in[7:6] == 2'b10);

  // lead byte decode
  always_comb begin
    lead_emit = 1'b0;
    lead_val  = '0;
    lead_pend = 2'd0;
    lead_acc  = '0;
    if (word.byte_in inside {[8'h00:8'h7F]}) begin
      lead_emit = 1'b1;
      lead_val  = {13'b0, word.byte_in};
    end else if (word.byte_in[7:5] == 3'b110) begin
      lead_pend = 2'd1;
      lead_acc  = {16'b0, word.byte_in[4:0]};
    end else if (word.byte_in[7:4] == 4'b1110) begin
      lead_pend = 2'd2;
      lead_acc  = {17'b0, word.byte_in[3:0]};
    end else if (word.byte_in[7:3] == 5'b11110) begin
      lead_pend = 2'd3;
      lead_acc  = {18'b0, word.byte_in[2:0]};
    end else begin
      lead_emit = 1'b1;
      lead_val  = REPLACEMENT;
    end
  end

  // sequence handling: first value is a finished or broken sequence,
  // second is a lead result or the partial value flushed at end of text
  always_comb begin
    v1_ok            = 1'b0;
    v1               = accumulator;
    v2_ok            = 1'b0;
    v2               = lead_val;
    pending_next     = pending;
    accumulator_next = accumulator;
    if ((pending != 2'd0) && cont) begin
      accumulator_next = {accumulator[14:0], word.byte_in[5:0]};
      pending_next     = pending - 2'd1;
      if (pending == 2'd1) begin
        v1_ok = 1'b1;
        v1    = accumulator_next;
      end
    end else begin
      if (pending != 2'd0) begin
        v1_ok            = 1'b1;
        accumulator_next = '0;
      end
      pending_next = lead_pend;
      if (lead_pend != 2'd0) begin
        accumulator_next = lead_acc;
      end
      v2_ok = lead_emit;
    end
    if (word.last_byte && (pending_next != 2'd0)) begin
      v2_ok = 1'b1;
      v2    = accumulator_next;
    end
    if (word.last_byte) begin
      pending_next     = 2'd0;
      accumulator_next = '0;
    end
  end

  assign s1 = split_value(v1, utf16_mode);
  assign s2 = split_value(v2, utf16_mode);

  // keep the first two code units
  always_comb begin
    step             = '0;
    step.first.unit  = s2.hi;
    step.second.unit = s2.lo;
    if (v1_ok) begin
      step.first.unit = s1.hi;
      if (s1.two) begin
        step.second.unit = s1.lo;
        step.count       = 2'd2;
      end else if (v2_ok) begin
        step.second.unit = s2.hi;
        step.count       = 2'd2;
      end else begin
        step.count = 2'd1;
      end
    end else if (v2_ok) begin
      step.count = s2.two ? 2'd2 : 2'd1;
    end
    step.first.last_of_run  = (step.count == 2'd1);
    step.first.end_of_text  = (step.count == 2'd1) && word.last_byte;
    step.second.last_of_run = 1'b1;
    step.second.end_of_text = word.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 2'd0;
      accumulator <= '0;
    end else if (accept) begin
      pending     <= pending_next;
      accumulator <= accumulator_next;
    end
  end

  `ASSERT_NEXT(last_closes_seq, accept && word.last_byte, pending == 2'd0)
  `ASSERT_NOW(last_gives_word, !(accept && word.last_byte) || (step.count != 2'd0))
  `ASSERT_NOW(pair_marks_second, (step.count != 2'd2) || !step.first.last_of_run)
  `ASSERT_NEXT(seq_step_down, accept && (pending != 2'd0) && cont,
               (pending == $past(pending) - 2'd1) || $past(word.last_byte))

endmodule

// File: hdl/utf8_to_utf16_decoder.sv
// utf-8 decoder: the words of an accepted byte are registered into the output queue and leave from its head on dst
// takes one byte a cycle while src_stall is low; each byte yields zero, one or two words through the output queue
// dst moves one word a cycle while dst_stall is low, so bytes giving two words set the rate while the queue fills
// src stalls while the queue holds more than QUEUE_DEPTH-2 words
// synchronous reset clears mode, decoder state and queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_utf16_decoder import utd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = AW + 1;

  logic            utf16_mode;
  logic            accept;
  logic            pop;
  step_t           step;
  logic [CW-1:0]   push_n;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  out_word_t       queue [QUEUE_DEPTH];

  assign src_stall = (count > CW'(QUEUE_DEPTH - 2));
  assign accept    = src_valid && !src_stall;
  assign dst_valid = (count != '0);
  assign pop       = dst_valid && !dst_stall;
  assign dst_word  = queue[head];

  utd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .utf16_mode (utf16_mode),
    .accept     (accept),
    .word       (src_word),
    .step       (step)
  );

  assign push_n     = accept ? CW'(step.count) : '0;
  assign count_next = count + push_n - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode <= 1'b0;
    end else if (cfg_write) begin
      utf16_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + AW'(pop);
      tail  <= tail + push_n[AW-1:0];
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (step.count != 2'd0)) begin
      queue[tail] <= step.first;
    end
    if (accept && (step.count == 2'd2)) begin
      queue[tail + AW'(1)] <= step.second;
    end
  end

  `ASSERT_NOW(queue_bound, count <= CW'(QUEUE_DEPTH))
  `ASSERT_NEXT(count_tracks, 1'b1,
               count == $past(count) + $past(push_n) - CW'($past(pop)))
  `ASSERT_NEXT(push_shows, accept && (step.count != 2'd0), dst_valid)

endmodule
